// File: rtl/spr_pkg.sv
// Shared types, constants and codes for the serial port ring buffers.
package spr_pkg;

  // Sizes fixed by the field widths.
  localparam int ByteW = 8;
  localparam int CmdW = 3;
  localparam int CountW = 7;
  localparam int CfgIdxW = 1;
  localparam int BufferDepthDefault = 64;
  localparam int ResultCap = 64;
  localparam int QueueDepth = 2;

  localparam logic [ByteW-1:0] LineEndReset = 8'd10;

  // Command codes as they arrive on the input channel.
  localparam logic [CmdW-1:0] CMD_RX_BYTE    = 3'd0;
  localparam logic [CmdW-1:0] CMD_TX_BYTE    = 3'd1;
  localparam logic [CmdW-1:0] CMD_TX_READY   = 3'd2;
  localparam logic [CmdW-1:0] CMD_READ       = 3'd3;
  localparam logic [CmdW-1:0] CMD_LINE_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_PORT_OPEN = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LINE_END  = 1'b1;

  // Operation after classification by the front end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RX_PUSH,
    OP_TX_PUSH,
    OP_TX_READY,
    OP_READ,
    OP_LINE_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_OPEN,
    ST_TOO_BIG,
    ST_NOTHING
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_KICK,
    BK_READ
  } back_state_t;

  // One classified item held in the queue.
  typedef struct packed {
    op_t               op;
    logic [ByteW-1:0]  data;
    logic              first;
    logic              last_of_msg;
    logic [CountW-1:0] msg_len;
    logic [CountW-1:0] limit;
  } work_t;

  typedef struct packed {
    logic             port_open;
    logic [ByteW-1:0] line_end;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic              host_byte_valid;
    logic [ByteW-1:0]  host_byte;
    logic              line_byte_valid;
    logic [ByteW-1:0]  line_byte;
    status_t           status;
    logic              last;
    logic              rx_line_ready;
    logic              overflow_error;
    logic [CountW-1:0] rx_count;
    logic [CountW-1:0] tx_count;
  } result_t;

endpackage

// File: rtl/spr_front.sv
// Front end: accepts input beats, decodes the command and works out the read limit.
module spr_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [spr_pkg::CmdW-1:0]   cmd,
  input  logic [spr_pkg::ByteW-1:0]  data_byte,
  input  logic                     first_of_message,
  input  logic                     last_of_message,
  input  logic [spr_pkg::CountW-1:0] message_length,
  input  logic [spr_pkg::CountW-1:0] max_bytes,
  input  logic                     q_full,
  output logic                     q_push,
  output spr_pkg::work_t           q_work
);
  import spr_pkg::*;

  localparam logic [CountW-1:0] CapLimit = CountW'(ResultCap);

  logic [CountW-1:0] limit;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // At most max_bytes - 1 bytes, and never more than the result cap.
  always_comb begin
    priority if (max_bytes == '0) begin
      limit = '0;
    end else if (max_bytes - 1'b1 > CapLimit) begin
      limit = CapLimit;
    end else begin
      limit = max_bytes - 1'b1;
    end
  end

  // Command decode; undefined codes become a no-operation.
  always_comb begin
    q_work.data        = data_byte;
    q_work.first       = first_of_message;
    q_work.last_of_msg = last_of_message;
    q_work.msg_len     = message_length;
    q_work.limit       = limit;
    unique case (cmd)
      CMD_RX_BYTE:   q_work.op = OP_RX_PUSH;
      CMD_TX_BYTE:   q_work.op = OP_TX_PUSH;
      CMD_TX_READY:  q_work.op = OP_TX_READY;
      CMD_READ:      q_work.op = OP_READ;
      CMD_LINE_READ: q_work.op = OP_LINE_READ;
      default:       q_work.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/spr_queue.sv
// Short queue of classified items between the front end and the back end.
module spr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spr_pkg::work_t push_work,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output spr_pkg::work_t head_work
);
  import spr_pkg::*;

  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);
  localparam logic [QPtrW-1:0] QPtrLast = QPtrW'(QueueDepth - 1);
  localparam logic [QCntW-1:0] QCntFull = QCntW'(QueueDepth);

  work_t            entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full      = (count == QCntFull);
  assign valid     = (count != '0);
  assign head_work = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_work;
    end
  end

endmodule

// File: rtl/spr_back.sv
// Back end: ring buffer memories, flags, transmit kick and the read loop.
module spr_back #(
  parameter int BUFFER_DEPTH = spr_pkg::BufferDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  spr_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  spr_pkg::work_t   q_work,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output spr_pkg::result_t res
);
  import spr_pkg::*;

  localparam int PtrW = $clog2(BUFFER_DEPTH);
  localparam int FillW = $clog2(BUFFER_DEPTH + 1);
  localparam int CmpW = (FillW > CountW) ? FillW : CountW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(BUFFER_DEPTH - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(BUFFER_DEPTH);

  back_state_t state, state_next;

  logic [ByteW-1:0] rx_mem [BUFFER_DEPTH];
  logic [ByteW-1:0] tx_mem [BUFFER_DEPTH];
  logic [ByteW-1:0] rx_rd;
  logic [ByteW-1:0] tx_rd;

  logic [PtrW-1:0]  rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [PtrW-1:0]  tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [FillW-1:0] rx_fill, rx_fill_next, tx_fill, tx_fill_next;
  logic             line_ready, line_ready_next;
  logic             err_flag, err_flag_next;
  logic             tx_active, tx_active_next;
  logic             refused, refused_next;
  logic [CountW-1:0] remaining, remaining_next;
  logic             line_read, line_read_next;
  logic             bypass, bypass_next;
  logic [ByteW-1:0] bypass_byte, bypass_byte_next;
  status_t          pend_status, pend_status_next;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic             load_res;
  logic             go_kick, go_read, done;
  logic             out_free;
  logic [FillW-1:0] tx_fill_pushed;
  logic [CmpW-1:0]  tx_free;
  logic             stop;
  result_t          res_next;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !res_valid || res_ready;
  assign tx_free  = CmpW'(FillFull) - CmpW'(tx_fill);
  assign stop     = line_read && (rx_rd == cfg.line_end);

  // Datapath: buffer updates, memory enables and the next result beat.
  always_comb begin
    rx_head_next     = rx_head;
    rx_tail_next     = rx_tail;
    rx_fill_next     = rx_fill;
    tx_head_next     = tx_head;
    tx_tail_next     = tx_tail;
    tx_fill_next     = tx_fill;
    line_ready_next  = line_ready;
    err_flag_next    = err_flag;
    tx_active_next   = tx_active;
    refused_next     = refused;
    remaining_next   = remaining;
    line_read_next   = line_read;
    bypass_next      = bypass;
    bypass_byte_next = bypass_byte;
    pend_status_next = pend_status;
    tx_fill_pushed   = tx_fill;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    q_pop    = 1'b0;
    load_res = 1'b0;
    go_kick  = 1'b0;
    go_read  = 1'b0;
    done     = 1'b0;
    res_next = '0;
    res_next.status = ST_OK;
    res_next.last   = 1'b1;

    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_work.op)
            OP_RX_PUSH: begin
              load_res = 1'b1;
              if (rx_fill != FillFull) begin
                rx_we        = 1'b1;
                rx_head_next = ptr_inc(rx_head);
                rx_fill_next = rx_fill + 1'b1;
                if (q_work.data == cfg.line_end) begin
                  line_ready_next = 1'b1;
                end
              end else begin
                err_flag_next = 1'b1;
              end
            end
            OP_TX_PUSH: begin
              // Whole-message check on the opening byte.
              priority if (q_work.first && !cfg.port_open) begin
                refused_next    = 1'b1;
                res_next.status = ST_NOT_OPEN;
              end else if (q_work.first && (tx_free < CmpW'(q_work.msg_len))) begin
                refused_next    = 1'b1;
                res_next.status = ST_TOO_BIG;
              end else if (q_work.first) begin
                refused_next = 1'b0;
              end else if (refused) begin
                res_next.status = cfg.port_open ? ST_TOO_BIG : ST_NOT_OPEN;
              end
              if (!refused_next) begin
                if (tx_fill != FillFull) begin
                  tx_we          = 1'b1;
                  tx_head_next   = ptr_inc(tx_head);
                  tx_fill_pushed = tx_fill + 1'b1;
                end else begin
                  res_next.status = ST_TOO_BIG;
                end
              end
              tx_fill_next = tx_fill_pushed;
              // Start an idle transmitter after the closing byte.
              if (!refused_next && q_work.last_of_msg && !tx_active &&
                  (tx_fill_pushed != '0)) begin
                go_kick          = 1'b1;
                tx_active_next   = 1'b1;
                tx_fill_next     = tx_fill_pushed - 1'b1;
                tx_tail_next     = ptr_inc(tx_tail);
                pend_status_next = res_next.status;
                // An empty buffer hands over the byte just written.
                bypass_next      = (tx_fill == '0);
                bypass_byte_next = q_work.data;
                tx_re            = (tx_fill != '0);
              end else begin
                load_res = 1'b1;
              end
            end
            OP_TX_READY: begin
              if (tx_active && (tx_fill != '0)) begin
                go_kick          = 1'b1;
                tx_re            = 1'b1;
                tx_tail_next     = ptr_inc(tx_tail);
                tx_fill_next     = tx_fill - 1'b1;
                bypass_next      = 1'b0;
                pend_status_next = ST_OK;
              end else begin
                load_res = 1'b1;
                if (tx_active) begin
                  tx_active_next = 1'b0;
                end
              end
            end
            OP_READ, OP_LINE_READ: begin
              if (!cfg.port_open) begin
                load_res        = 1'b1;
                res_next.status = ST_NOT_OPEN;
              end else begin
                if (q_work.op == OP_LINE_READ) begin
                  line_ready_next = 1'b0;
                end
                if ((q_work.limit == '0) || (rx_fill == '0)) begin
                  load_res        = 1'b1;
                  res_next.status = ST_NOTHING;
                end else begin
                  go_read        = 1'b1;
                  rx_re          = 1'b1;
                  rx_tail_next   = ptr_inc(rx_tail);
                  rx_fill_next   = rx_fill - 1'b1;
                  remaining_next = q_work.limit - 1'b1;
                  line_read_next = (q_work.op == OP_LINE_READ);
                end
              end
            end
            default: begin
              load_res = 1'b1;
            end
          endcase
        end
      end
      BK_KICK: begin
        if (out_free) begin
          load_res                 = 1'b1;
          done                     = 1'b1;
          res_next.line_byte_valid = 1'b1;
          res_next.line_byte       = bypass ? bypass_byte : tx_rd;
          res_next.status          = pend_status;
        end
      end
      BK_READ: begin
        if (out_free) begin
          load_res                 = 1'b1;
          res_next.host_byte_valid = 1'b1;
          res_next.host_byte       = rx_rd;
          res_next.last            = stop || (remaining == '0) || (rx_fill == '0);
          if (res_next.last) begin
            done = 1'b1;
          end else begin
            // Fetch the following byte while this one goes out.
            rx_re          = 1'b1;
            rx_tail_next   = ptr_inc(rx_tail);
            rx_fill_next   = rx_fill - 1'b1;
            remaining_next = remaining - 1'b1;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    // Flags and levels as they stand after this beat.
    res_next.rx_line_ready  = line_ready_next;
    res_next.overflow_error = err_flag_next;
    res_next.tx_count       = CountW'(tx_fill_next);
    res_next.rx_count       = (state == BK_READ) ? CountW'(rx_fill) : CountW'(rx_fill_next);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        priority if (go_kick) begin
          state_next = BK_KICK;
        end else if (go_read) begin
          state_next = BK_READ;
        end
      end
      BK_KICK, BK_READ: begin
        if (done) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      rx_head    <= '0;
      rx_tail    <= '0;
      rx_fill    <= '0;
      tx_head    <= '0;
      tx_tail    <= '0;
      tx_fill    <= '0;
      line_ready <= 1'b0;
      err_flag   <= 1'b0;
      tx_active  <= 1'b0;
      refused    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rx_head    <= rx_head_next;
      rx_tail    <= rx_tail_next;
      rx_fill    <= rx_fill_next;
      tx_head    <= tx_head_next;
      tx_tail    <= tx_tail_next;
      tx_fill    <= tx_fill_next;
      line_ready <= line_ready_next;
      err_flag   <= err_flag_next;
      tx_active  <= tx_active_next;
      refused    <= refused_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output beat.
  always_ff @(posedge clk) begin
    remaining   <= remaining_next;
    line_read   <= line_read_next;
    bypass      <= bypass_next;
    bypass_byte <= bypass_byte_next;
    pend_status <= pend_status_next;
    if (load_res) begin
      res <= res_next;
    end
  end

  // Receive buffer memory.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head] <= q_work.data;
    end
    if (rx_re) begin
      rx_rd <= rx_mem[rx_tail];
    end
  end

  // Transmit buffer memory.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_head] <= q_work.data;
    end
    if (tx_re) begin
      tx_rd <= tx_mem[tx_tail];
    end
  end

endmodule

// File: rtl/serial_port_ring_buffers_unit.sv
// An accepted beat is queued; the back end pops it once the output is free and
// registers its result beat. Byte, message and undefined commands finish in the idle
// state; a transmit pop also passes the kick state, as the transmit buffer memory has a
// registered read port. Host reads return one byte per cycle unless stalled (at most 64).
// Reset (rst, synchronous): buffers empty, flags clear, transmitter idle, port closed,
// line end 10; buffer contents are not cleared and no clearing pass is run.
module serial_port_ring_buffers_unit #(
  parameter int BUFFER_DEPTH = spr_pkg::BufferDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [spr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [spr_pkg::ByteW-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spr_pkg::CmdW-1:0]    cmd,
  input  logic [spr_pkg::ByteW-1:0]   data_byte,
  input  logic                        first_of_message,
  input  logic                        last_of_message,
  input  logic [spr_pkg::CountW-1:0]  message_length,
  input  logic [spr_pkg::CountW-1:0]  max_bytes,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        host_byte_valid,
  output logic [spr_pkg::ByteW-1:0]   host_byte,
  output logic                        line_byte_valid,
  output logic [spr_pkg::ByteW-1:0]   line_byte,
  output logic [1:0]                  status,
  output logic                        last,
  output logic                        rx_line_ready,
  output logic                        overflow_error,
  output logic [spr_pkg::CountW-1:0]  rx_count,
  output logic [spr_pkg::CountW-1:0]  tx_count
);
  import spr_pkg::*;

  cfg_t    cfg;
  logic    q_full, q_push, q_pop, q_valid;
  work_t   push_work, head_work;
  result_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_open <= 1'b0;
      cfg.line_end  <= LineEndReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PORT_OPEN: cfg.port_open <= cfg_data[0];
        REG_LINE_END:  cfg.line_end  <= cfg_data;
        default: ;
      endcase
    end
  end

  spr_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .last_of_message  (last_of_message),
    .message_length   (message_length),
    .max_bytes        (max_bytes),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_work           (push_work)
  );

  spr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_work (push_work),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_work (head_work)
  );

  spr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_work    (head_work),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // Result beat fields.
  assign host_byte_valid = res.host_byte_valid;
  assign host_byte       = res.host_byte;
  assign line_byte_valid = res.line_byte_valid;
  assign line_byte       = res.line_byte;
  assign status          = res.status;
  assign last            = res.last;
  assign rx_line_ready   = res.rx_line_ready;
  assign overflow_error  = res.overflow_error;
  assign rx_count        = res.rx_count;
  assign tx_count        = res.tx_count;

endmodule

// File: rtl/spr_checker.sv
// Port-level checks on the result channel, bound to the top level.
module spr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       host_byte_valid,
  input logic [spr_pkg::ByteW-1:0]  host_byte,
  input logic                       line_byte_valid,
  input logic [1:0]                 status,
  input logic                       last,
  input logic                       overflow_error
);
  import spr_pkg::*;

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(host_byte) && $stable(status) &&
                                $stable(last))
    else $error("result beat changed while stalled");

  // Only popped read bytes may be followed by further beats of the same item.
  a_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> host_byte_valid)
    else $error("non-final beat without a host byte");

  // A host byte never travels with a line byte or an error status.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && host_byte_valid |-> !line_byte_valid && (status == ST_OK))
    else $error("host byte beat carries line byte or error");

  // The overflow flag is sticky until reset.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_error |=> !out_valid || overflow_error)
    else $error("overflow flag fell without reset");

endmodule

bind serial_port_ring_buffers_unit spr_checker u_spr_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .host_byte_valid (host_byte_valid),
  .host_byte       (host_byte),
  .line_byte_valid (line_byte_valid),
  .status          (status),
  .last            (last),
  .overflow_error  (overflow_error)
);

// File: tb/tb_serial_port_ring_buffers_unit.sv
// Self-checking testbench for the serial port ring buffers unit.
`timescale 1ns / 100ps

module tb_serial_port_ring_buffers_unit;
  import spr_pkg::*;

  localparam int Depth = BufferDepthDefault;
  localparam int PtrW = $clog2(Depth);
  localparam logic [CmdW-1:0] CMD_SPARE_FIRST = CMD_LINE_READ + 3'd1;
  localparam logic [CmdW-1:0] CMD_SPARE_LAST = '1;
  localparam int MaxLength = Depth;
  localparam int MaxRequest = Depth + 1;
  localparam int SettleCycles = 4;
  localparam int TailCycles = 80;
  localparam int ReadyBurst = 16;

  // One input beat as the sender presents it.
  typedef struct {
    logic [CmdW-1:0]   cmd;
    logic [ByteW-1:0]  data;
    logic              first;
    logic              close;
    logic [CountW-1:0] mlen;
    logic [CountW-1:0] maxb;
  } port_item_t;

  // Mirror of both rings, the flags and the registers; it works out the
  // result beats that each accepted input beat must produce.
  class port_buffer_tracker;
    logic [ByteW-1:0] rx_mem [Depth];
    logic [ByteW-1:0] tx_mem [Depth];
    bit [PtrW-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
    int rx_used, tx_used;
    bit line_seen, dropped, tx_busy, refusing;
    bit port_open;
    logic [ByteW-1:0] line_end;
    result_t owed_beats[$];
    int errors;

    function new();
      line_end = LineEndReset;
    endfunction

    // Queue one result beat, taking the flags and fills as they stand now.
    function void owe(bit hv, logic [ByteW-1:0] hb, bit lv, logic [ByteW-1:0] lb,
                      status_t st, bit fin);
      result_t r;
      r.host_byte_valid = hv;
      r.host_byte = hb;
      r.line_byte_valid = lv;
      r.line_byte = lb;
      r.status = st;
      r.last = fin;
      r.rx_line_ready = line_seen;
      r.overflow_error = dropped;
      r.rx_count = CountW'(rx_used);
      r.tx_count = CountW'(tx_used);
      owed_beats.push_back(r);
    endfunction

    function logic [ByteW-1:0] tx_take();
      logic [ByteW-1:0] v;
      v = tx_mem[tx_rd];
      tx_rd++;
      tx_used--;
      return v;
    endfunction

    function void accept_item(port_item_t it);
      status_t st;
      bit lv;
      logic [ByteW-1:0] lb;
      logic [ByteW-1:0] c;
      int limit;
      int n;
      bit stop;
      st = ST_OK;
      lv = 1'b0;
      lb = '0;
      case (it.cmd)
        CMD_RX_BYTE: begin
          // Line bytes are taken even with the port closed.
          if (rx_used < Depth) begin
            rx_mem[rx_wr] = it.data;
            rx_wr++;
            rx_used++;
            if (it.data == line_end) line_seen = 1'b1;
          end else begin
            dropped = 1'b1;
          end
          owe(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
        end
        CMD_TX_BYTE: begin
          // The whole message is judged on its opening byte.
          if (it.first) begin
            if (!port_open) begin
              refusing = 1'b1;
              st = ST_NOT_OPEN;
            end else if (Depth - tx_used < int'(it.mlen)) begin
              refusing = 1'b1;
              st = ST_TOO_BIG;
            end else begin
              refusing = 1'b0;
            end
          end else if (refusing) begin
            st = port_open ? ST_TOO_BIG : ST_NOT_OPEN;
          end
          if (!refusing) begin
            if (tx_used < Depth) begin
              tx_mem[tx_wr] = it.data;
              tx_wr++;
              tx_used++;
            end else begin
              st = ST_TOO_BIG;
            end
            // The closing byte starts an idle transmitter.
            if (it.close && !tx_busy && tx_used > 0) begin
              tx_busy = 1'b1;
              lb = tx_take();
              lv = 1'b1;
            end
          end
          owe(1'b0, '0, lv, lb, st, 1'b1);
        end
        CMD_TX_READY: begin
          if (tx_busy) begin
            if (tx_used > 0) begin
              lb = tx_take();
              lv = 1'b1;
            end else begin
              tx_busy = 1'b0;
            end
          end
          owe(1'b0, '0, lv, lb, ST_OK, 1'b1);
        end
        CMD_READ, CMD_LINE_READ: begin
          if (!port_open) begin
            owe(1'b0, '0, 1'b0, '0, ST_NOT_OPEN, 1'b1);
          end else begin
            limit = it.maxb > 0 ? int'(it.maxb) - 1 : 0;
            if (limit > ResultCap) limit = ResultCap;
            if (it.cmd == CMD_LINE_READ) line_seen = 1'b0;
            n = 0;
            stop = 1'b0;
            while (n < limit && rx_used > 0 && !stop) begin
              c = rx_mem[rx_rd];
              rx_rd++;
              rx_used--;
              if (it.cmd == CMD_LINE_READ && c == line_end) stop = 1'b1;
              owe(1'b1, c, 1'b0, '0, ST_OK, 1'b0);
              n++;
            end
            if (n == 0) owe(1'b0, '0, 1'b0, '0, ST_NOTHING, 1'b1);
            else owed_beats[owed_beats.size() - 1].last = 1'b1;
          end
        end
        default: begin
          owe(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_field(string name, logic [ByteW-1:0] want, logic [ByteW-1:0] got);
      if (got !== want) begin
        if (errors < 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (owed_beats.size() == 0) begin
        if (errors < 40)
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_beats.pop_front();
      check_field("host_byte_valid", want.host_byte_valid, got.host_byte_valid);
      check_field("host_byte", want.host_byte, got.host_byte);
      check_field("line_byte_valid", want.line_byte_valid, got.line_byte_valid);
      check_field("line_byte", want.line_byte, got.line_byte);
      check_field("status", want.status, got.status);
      check_field("last", want.last, got.last);
      check_field("rx_line_ready", want.rx_line_ready, got.rx_line_ready);
      check_field("overflow_error", want.overflow_error, got.overflow_error);
      check_field("rx_count", want.rx_count, got.rx_count);
      check_field("tx_count", want.tx_count, got.tx_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CmdW-1:0] cmd = '0;
  logic [ByteW-1:0] data_byte = '0;
  logic first_of_message = 1'b0;
  logic last_of_message = 1'b0;
  logic [CountW-1:0] message_length = '0;
  logic [CountW-1:0] max_bytes = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic host_byte_valid;
  logic [ByteW-1:0] host_byte;
  logic line_byte_valid;
  logic [ByteW-1:0] line_byte;
  logic [1:0] status;
  logic last;
  logic rx_line_ready;
  logic overflow_error;
  logic [CountW-1:0] rx_count;
  logic [CountW-1:0] tx_count;

  result_t seen;
  port_buffer_tracker tracker = new();
  int burst_left = 0;

  serial_port_ring_buffers_unit uut (.*);

  assign seen = {host_byte_valid, host_byte, line_byte_valid, line_byte, status, last,
                 rx_line_ready, overflow_error, rx_count, tx_count};

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: checks each accepted beat and stalls in segments of varying shape.
  int seg_left = 0;
  int seg_mode = 0;
  int seg_pos = 0;
  int seg_period = 2;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_beat(seen);
    if (seg_left == 0) begin
      seg_left = $urandom_range(8, 64);
      seg_mode = $urandom_range(0, 3);
      seg_period = $urandom_range(2, 4);
      seg_pos = 0;
    end
    case (seg_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (seg_pos % seg_period == 0);
      default: out_ready <= (seg_pos >= 12);
    endcase
    seg_pos++;
    seg_left--;
  end

  function automatic port_item_t make_item(logic [CmdW-1:0] c, logic [ByteW-1:0] d,
                                           logic f, logic l, int ml, int mb);
    port_item_t it;
    it.cmd = c;
    it.data = d;
    it.first = f;
    it.close = l;
    it.mlen = CountW'(ml);
    it.maxb = CountW'(mb);
    return it;
  endfunction

  // Every field random, lengths up to the depth and requests up to one past it; sequences then pin what they need.
  function automatic port_item_t any_item();
    return make_item(CmdW'($urandom_range(0, CMD_SPARE_LAST)), ByteW'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, MaxLength), $urandom_range(0, MaxRequest));
  endfunction

  // Present one beat and wait for it to be taken; the sender may idle between bursts.
  task automatic send_item(port_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= it.cmd;
    data_byte <= it.data;
    first_of_message <= it.first;
    last_of_message <= it.close;
    message_length <= it.mlen;
    max_bytes <= it.maxb;
    do @(posedge clk); while (!in_ready);
    tracker.accept_item(it);
  endtask

  // Hold the sender until every owed result has arrived and the block is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.owed_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_PORT_OPEN) tracker.port_open = value[0];
    else tracker.line_end = value;
  endtask

  // Mostly well-formed traffic with random content, plus some noise.
  task automatic random_mix(int count);
    port_item_t it;
    int sent;
    int len;
    int pick;
    int i;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
          it = any_item();
          it.cmd = CMD_TX_BYTE;
          it.first = (i == 0);
          it.close = (i == len - 1);
          if (i == 0 && $urandom_range(0, 4) != 0) it.mlen = CountW'(len);
          send_item(it);
        end
        sent += len;
      end else if (pick < 45) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          it = any_item();
          it.cmd = CMD_RX_BYTE;
          if ($urandom_range(0, 3) == 0) it.data = tracker.line_end;
          send_item(it);
        end
        sent += len;
      end else if (pick < 70) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          it = any_item();
          it.cmd = CMD_TX_READY;
          send_item(it);
        end
        sent += len;
      end else if (pick < 88) begin
        it = any_item();
        it.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_LINE_READ;
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: it.maxb = '0;
            1: it.maxb = CountW'(1);
            2: it.maxb = CountW'(MaxLength);
            default: it.maxb = CountW'(MaxRequest);
          endcase
        end else begin
          it.maxb = CountW'($urandom_range(2, 20));
        end
        send_item(it);
        sent++;
      end else begin
        send_item(any_item());
        sent++;
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    port_item_t it;
    int i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_PORT_OPEN, 8'd0);
    write_reg(REG_LINE_END, LineEndReset);

    // Port closed: line bytes still land, host operations are refused.
    send_item(make_item(CMD_RX_BYTE, LineEndReset, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_RX_BYTE, 8'hFF, 1'b1, 1'b1, MaxLength, MaxRequest));
    send_item(make_item(CMD_TX_BYTE, 8'h00, 1'b1, 1'b1, 1, 0));
    send_item(make_item(CMD_TX_BYTE, 8'hAA, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_READ, 8'h00, 1'b0, 1'b0, 0, MaxRequest));
    send_item(make_item(CMD_LINE_READ, 8'h00, 1'b0, 1'b0, 0, MaxRequest));
    send_item(make_item(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_SPARE_FIRST, 8'hFF, 1'b1, 1'b1, MaxLength, MaxRequest));
    send_item(make_item(CMD_SPARE_LAST, 8'h00, 1'b0, 1'b0, 0, 0));
    drain_results();
    write_reg(REG_PORT_OPEN, 8'd1);

    // Port open: empty requests, line reads stopping at line end, kicks and refusals.
    send_item(make_item(CMD_READ, 8'h00, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_LINE_READ, 8'h00, 1'b0, 1'b0, 0, MaxRequest));
    send_item(make_item(CMD_RX_BYTE, LineEndReset, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_LINE_READ, 8'h00, 1'b0, 1'b0, 0, 1));
    send_item(make_item(CMD_READ, 8'h00, 1'b0, 1'b0, 0, MaxRequest));
    send_item(make_item(CMD_READ, 8'h00, 1'b0, 1'b0, 0, 1));
    send_item(make_item(CMD_TX_BYTE, 8'h01, 1'b1, 1'b0, MaxLength, 0));
    send_item(make_item(CMD_TX_BYTE, 8'h80, 1'b0, 1'b1, 0, 0));
    send_item(make_item(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_TX_BYTE, 8'h3C, 1'b1, 1'b0, 1, 0));
    send_item(make_item(CMD_TX_BYTE, 8'hC3, 1'b1, 1'b0, MaxLength, 0));
    send_item(make_item(CMD_TX_BYTE, 8'h5A, 1'b0, 1'b1, 0, 0));
    send_item(make_item(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 0, 0));
    drain_results();

    // Receive flood: overflow sets the sticky error, then empty the ring.
    random_mix(10);
    for (i = 0; i < Depth + 2; i++) begin
      it = any_item();
      it.cmd = CMD_RX_BYTE;
      if ($urandom_range(0, 7) == 0) it.data = tracker.line_end;
      send_item(it);
    end
    send_item(make_item(CMD_LINE_READ, 8'h00, 1'b0, 1'b0, 0, MaxRequest));
    send_item(make_item(CMD_READ, 8'h00, 1'b0, 1'b0, 0, MaxRequest));
    drain_results();

    // Transmit flood with line end at its lowest value: full ring, drops, refusal.
    write_reg(REG_LINE_END, 8'd0);
    random_mix(10);
    send_item(make_item(CMD_TX_BYTE, ByteW'($urandom_range(0, 255)), 1'b1, 1'b0, 0, 0));
    for (i = 0; i < Depth + 1; i++) begin
      it = any_item();
      it.cmd = CMD_TX_BYTE;
      it.first = 1'b0;
      it.close = 1'b0;
      send_item(it);
    end
    send_item(make_item(CMD_TX_BYTE, 8'hE7, 1'b0, 1'b1, 0, 0));
    send_item(make_item(CMD_TX_BYTE, 8'h11, 1'b1, 1'b0, MaxLength, 0));
    send_item(make_item(CMD_TX_BYTE, 8'h22, 1'b0, 1'b0, 0, 0));
    send_item(make_item(CMD_TX_BYTE, 8'h33, 1'b0, 1'b1, 0, 0));
    for (i = 0; i < ReadyBurst; i++) begin
      it = any_item();
      it.cmd = CMD_TX_READY;
      send_item(it);
    end
    drain_results();

    // Port closed again, line end at its highest value.
    write_reg(REG_PORT_OPEN, 8'd0);
    write_reg(REG_LINE_END, 8'hFF);
    random_mix(10);
    drain_results();

    // Port open with a random line end.
    write_reg(REG_PORT_OPEN, 8'd1);
    write_reg(REG_LINE_END, ByteW'($urandom_range(0, 255)));
    random_mix(15);

    in_valid <= 1'b0;
    while (tracker.owed_beats.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("[serial_port_ring_buffers_unit] OK");
    end else begin
      $display("[serial_port_ring_buffers_unit] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("[serial_port_ring_buffers_unit] ERROR");
    $finish;
  end

endmodule
